>>> design/sdc_pkg.sv
// Shared widths and controller/datapath interface types for the distinct count block.
package sdc_pkg;

    localparam int IN_ID_W   = 14;   // member_id field width
    localparam int OUT_W     = 15;   // distinct_count field width
    localparam int TDATA_W   = 16;   // both channels padded to whole bytes
    localparam int FLAG_W    = 2;

    localparam logic [OUT_W-1:0]  OUT_MAX     = 15'h7FFF;
    localparam logic [FLAG_W-1:0] FLAG_DIRECT = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_SECOND = 2'b10;
    localparam logic              ACT_DIRECT  = 1'b0;

    // Controller to datapath
    typedef struct packed {
        logic clr_we;   // write zero at clear pointer, advance pointer
        logic accept;   // capture input beat, launch flag read
        logic commit;   // write back flags, update count, load result
    } sdc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last; // clear pointer sits on the last entry
        logic out_free; // result register can take a new beat this cycle
    } sdc_sts_t;

endpackage

>>> design/set_difference_distinct_count.sv
// Top level: distinct count of second-level IDs that are never direct members.
//
// Input stream: one beat per ID. s_tuser carries the action (0 = direct
// member, 1 = second-level member), s_tdata[13:0] the member ID.
// Output stream: one beat per input beat; m_tdata[14:0] holds the running
// count after that ID, saturated at 32767.
// Each ID does a read-modify-write of a 2-bit flag entry (direct, second) in a
// 2^ID_BITS-deep RAM; the flag RAM read port sets the pace.
// A new beat is taken only once the last one is committed (accept, then the
// flag read returns and is written back). m_tvalid rises when the commit,
// which waits while the output is full, writes the flags and loads the result.
// Reset: aresetn (synchronous, active low) clears the count and runs a clearing
// pass over the flag RAM, one entry per cycle, all 2^ID_BITS entries (16384 at the
// default) with s_tready low throughout.
// Stall: the result register holds its beat while m_tready is low. One more
// input beat is taken meanwhile; its commit waits until the output frees up.
module set_difference_distinct_count #(
    parameter int ID_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] member_id, [15:14] zero
    input  logic        s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [14:0] distinct_count, [15] zero
);

    sdc_pkg::sdc_cmd_t cmd;
    sdc_pkg::sdc_sts_t sts;

    // sequencing: clear pass, intake, commit
    sdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // flag store, counter and result register
    sdc_dp #(
        .ID_BITS (ID_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> design/sdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/sdc_ctrl.sv
// Controller state machine: clearing pass, beat intake, read-modify-write commit.
module sdc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sdc_pkg::sdc_sts_t sts,
    output sdc_pkg::sdc_cmd_t cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // flags are in the read register; wait for room at the output
                cmd.commit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/sdc_dp.sv
// Datapath: flag store, clear pointer, running count and result register.
module sdc_dp #(
    parameter int ID_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sdc_pkg::sdc_cmd_t             cmd,
    output sdc_pkg::sdc_sts_t             sts,
    input  logic [sdc_pkg::TDATA_W-1:0]   s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sdc_pkg::TDATA_W-1:0]   m_tdata
);

    localparam int DEPTH = 2 ** ID_BITS;
    localparam int CNT_W = ID_BITS + 1;
    localparam int SAT_W = (CNT_W > sdc_pkg::OUT_W) ? CNT_W : sdc_pkg::OUT_W;

    logic [ID_BITS-1:0]        clr_ptr_reg;
    logic [ID_BITS-1:0]        id_reg;
    logic                      act_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      m_tvalid_reg;
    logic [sdc_pkg::OUT_W-1:0] m_data_reg;
    logic [sdc_pkg::OUT_W-1:0] m_data_next;
    logic [SAT_W-1:0]          count_wide;

    logic [sdc_pkg::FLAG_W-1:0] flags_rd;
    logic [sdc_pkg::FLAG_W-1:0] flags_new;
    logic                       ram_we;
    logic [ID_BITS-1:0]         ram_waddr;
    logic [sdc_pkg::FLAG_W-1:0] ram_wdata;
    logic [ID_BITS-1:0]         in_id;

    // IDs beyond the store wrap; narrow stores drop high bits
    assign in_id = ID_BITS'(s_tdata[sdc_pkg::IN_ID_W-1:0]);

    always_comb begin
        count_next = count_reg;
        if (act_reg == sdc_pkg::ACT_DIRECT) begin
            if ((flags_rd == sdc_pkg::FLAG_SECOND) && (count_reg != '0)) begin
                count_next = count_reg - CNT_W'(1);
            end
            flags_new = flags_rd | sdc_pkg::FLAG_DIRECT;
        end else begin
            if (flags_rd == '0) begin
                count_next = count_reg + CNT_W'(1);
            end
            flags_new = flags_rd | sdc_pkg::FLAG_SECOND;
        end
    end

    // saturate to the output field
    assign count_wide  = SAT_W'(count_next);
    assign m_data_next = (count_wide > SAT_W'(sdc_pkg::OUT_MAX)) ? sdc_pkg::OUT_MAX
                                                                  : sdc_pkg::OUT_W'(count_wide);

    assign ram_we    = cmd.clr_we | cmd.commit;
    assign ram_waddr = cmd.clr_we ? clr_ptr_reg : id_reg;
    assign ram_wdata = cmd.clr_we ? '0 : flags_new;

    sdc_ram #(
        .WIDTH (sdc_pkg::FLAG_W),
        .DEPTH (DEPTH)
    ) u_flags (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (in_id),
        .rdata (flags_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg  <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clr_we) begin
                clr_ptr_reg <= clr_ptr_reg + ID_BITS'(1);
            end
            if (cmd.commit) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            id_reg  <= in_id;
            act_reg <= s_tuser;
        end
        if (cmd.commit) begin
            m_data_reg <= m_data_next;
        end
    end

    always_comb begin
        sts          = '0;
        sts.clr_last = (clr_ptr_reg == {ID_BITS{1'b1}});
        sts.out_free = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(sdc_pkg::TDATA_W - sdc_pkg::OUT_W){1'b0}}, m_data_reg};

endmodule

>>> tb/set_difference_distinct_count_tb.sv
// Testbench for set_difference_distinct_count: random stream traffic against a predicted count.
`timescale 1ns / 1ps

module set_difference_distinct_count_tb;

    localparam logic ACT_SECOND   = 1'b1;        // second-level member
    localparam int   STORE_DEPTH  = 1 << sdc_pkg::IN_ID_W;
    localparam int   RANDOM_BEATS = 600;
    localparam int   QUIET_TAIL   = 100;         // last beats run with no idling
    localparam int   STALL_LIMIT  = 60000;       // covers the clear pass over all 16384 entries
    localparam int   DRAIN_CYCLES = 8;

    // Tracks the flag store and running count; holds the counts still owed by the DUT.
    class member_count_board;
        bit [sdc_pkg::FLAG_W-1:0]  id_flags [STORE_DEPTH];
        int unsigned               live_count;
        logic [sdc_pkg::OUT_W-1:0] owed_counts [$];
        int unsigned               errors;

        function new();
            live_count = 0;
            errors     = 0;
            foreach (id_flags[i]) id_flags[i] = '0;
        endfunction

        // Accepted input beat: update flags and count, queue the count it returns.
        function void record_id(logic act, logic [sdc_pkg::IN_ID_W-1:0] id);
            bit [sdc_pkg::FLAG_W-1:0] f;
            f = id_flags[id];
            if (act == sdc_pkg::ACT_DIRECT) begin
                // direct hit on a counted ID takes it back out
                if ((f & sdc_pkg::FLAG_SECOND) != 0 && (f & sdc_pkg::FLAG_DIRECT) == 0 &&
                    live_count > 0)
                    live_count--;
                f = f | sdc_pkg::FLAG_DIRECT;
            end else begin
                // only a never-seen ID counts; already direct or second is a no-op
                if (f == '0)
                    live_count++;
                f = f | sdc_pkg::FLAG_SECOND;
            end
            id_flags[id] = f;
            owed_counts.push_back((live_count > sdc_pkg::OUT_MAX) ?
                                  sdc_pkg::OUT_MAX : live_count[sdc_pkg::OUT_W-1:0]);
        endfunction

        // Accepted result beat: compare against the oldest owed count.
        function void compare_count(logic [sdc_pkg::TDATA_W-1:0] beat);
            logic [sdc_pkg::OUT_W-1:0] want;
            if (owed_counts.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual count %0d",
                         $time, beat[sdc_pkg::OUT_W-1:0]);
                errors++;
                return;
            end
            want = owed_counts.pop_front();
            if (beat[sdc_pkg::OUT_W-1:0] !== want) begin
                $display("%0t: distinct_count mismatch, expected %0d, actual %0d",
                         $time, want, beat[sdc_pkg::OUT_W-1:0]);
                errors++;
            end
            if (beat[sdc_pkg::TDATA_W-1:sdc_pkg::OUT_W] !== '0) begin
                $display("%0t: m_tdata pad mismatch, expected 0, actual %0h",
                         $time, beat[sdc_pkg::TDATA_W-1:sdc_pkg::OUT_W]);
                errors++;
            end
        endfunction

        function int owed();
            return owed_counts.size();
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [sdc_pkg::TDATA_W-1:0]  s_tdata;
    logic                         s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [sdc_pkg::TDATA_W-1:0]  m_tdata;

    member_count_board   board;
    bit                  idle_on;     // random gaps and stalls allowed
    int                  quiet_cycles;

    set_difference_distinct_count u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Monitor: both channels sampled at the edge, before any NBA lands.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.record_id(s_tuser, s_tdata[sdc_pkg::IN_ID_W-1:0]);
            if (m_tvalid && m_tready)
                board.compare_count(m_tdata);
        end
    end

    // Watchdog: run of cycles with no beat on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("set_difference_distinct_count_tb: errors");
            $finish;
        end
    end

    // Result side: ready is redrawn in random-length bursts and drops at random while idling is on.
    initial begin
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            n = $urandom_range(1, 16);
            m_tready <= !(idle_on && $urandom_range(0, 2) == 0);
            repeat (n) @(posedge aclk);
        end
    end

    // One input beat; valid stays high across back-to-back beats.
    task automatic send_beat(logic act, logic [sdc_pkg::IN_ID_W-1:0] id);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(sdc_pkg::TDATA_W-sdc_pkg::IN_ID_W){1'b0}}, id};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random ID: mostly small pools so repeats and cross-action hits are common.
    function automatic logic [sdc_pkg::IN_ID_W-1:0] pick_id();
        int          r;
        int unsigned v;
        r = $urandom_range(0, 19);
        if (r < 12)
            v = $urandom_range(0, 63);
        else if (r < 17)
            v = $urandom_range(0, 1023);
        else
            v = $urandom_range(0, STORE_DEPTH - 1);
        return v[sdc_pkg::IN_ID_W-1:0];
    endfunction

    initial begin
        board        = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        idle_on      = 1'b1;
        quiet_cycles = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of the ID, repeats, direct/second interplay.
        send_beat(ACT_SECOND, 14'd0);        // new second-level ID counts
        send_beat(ACT_SECOND, 14'd0);        // repeated second: no change
        send_beat(sdc_pkg::ACT_DIRECT, 14'd0);   // counted ID turns direct: count drops
        send_beat(sdc_pkg::ACT_DIRECT, 14'd0);   // repeated direct: no change
        send_beat(ACT_SECOND, 14'd0);        // second on a direct ID: not counted
        send_beat(ACT_SECOND, 14'h3FFF);
        send_beat(ACT_SECOND, 14'h3FFF);
        send_beat(sdc_pkg::ACT_DIRECT, 14'h3FFF);
        send_beat(sdc_pkg::ACT_DIRECT, 14'd5);   // direct, never second
        send_beat(ACT_SECOND, 14'd5);        // later second use not counted
        send_beat(ACT_SECOND, 14'h2AAA);
        send_beat(ACT_SECOND, 14'h1555);
        send_beat(sdc_pkg::ACT_DIRECT, 14'h1555);
        send_beat(ACT_SECOND, 14'h2000);
        send_beat(ACT_SECOND, 14'h0001);
        send_beat(sdc_pkg::ACT_DIRECT, 14'h2AAA);
        send_beat(sdc_pkg::ACT_DIRECT, 14'h2AAA);
        send_beat(ACT_SECOND, 14'h2000);

        // Random: second-level leaning so the count climbs, then gets pulled down.
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            idle_on = !((i >= 300 && i < 350) || i >= RANDOM_BEATS - QUIET_TAIL);
            send_beat(($urandom_range(0, 9) < 6) ? ACT_SECOND : sdc_pkg::ACT_DIRECT,
                      pick_id());
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b0;

        while (board.owed() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.owed() == 0)
            $display("set_difference_distinct_count_tb: clean");
        else
            $display("set_difference_distinct_count_tb: errors");
        $finish;
    end

endmodule
